[sv/dpec_pkg.sv]
package dpec_pkg;

	localparam int RADIUS_BITS = 27;
	localparam int MAG_BITS = RADIUS_BITS + 1;
	localparam int RADIUS_RESET_INT = 5;

	localparam logic REG_RADIUS = 1'b0;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_HIT  = 2'd1,
		ST_COIN = 2'd2
	} status_t;

endpackage

[sv/dpec_dly.sv]
module dpec_dly #(
	parameter int DATA_BITS = 1,
	parameter int DEPTH = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [DATA_BITS-1:0] data_in,
	output logic [DATA_BITS-1:0] data_out
);

	logic [DATA_BITS-1:0] data_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				data_s[i] <= '0;
			end
		end else begin
			data_s[0] <= data_in;
			for (int i = 1; i < DEPTH; i++) begin
				data_s[i] <= data_s[i-1];
			end
		end
	end

	assign data_out = data_s[DEPTH-1];

endmodule

[sv/dpec_sqrt.sv]
module dpec_sqrt #(
	parameter int ROOT_BITS = 28
) (
	input  logic                   clk,
	input  logic [2*ROOT_BITS-1:0] rad,
	output logic [ROOT_BITS-1:0]   root
);

	localparam int RW = ROOT_BITS + 3;
	localparam int SB = 2 * ROOT_BITS;

	logic [RW-1:0]        rem_s  [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] root_s [ROOT_BITS+1];
	logic [SB-1:0]        rad_s  [ROOT_BITS+1];

	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = rad;

	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          ge;

		assign cur = {rem_s[i][RW-3:0], rad_s[i][SB-1 -: 2]};
		assign trial = RW'({root_s[i], 2'b01});
		assign ge = cur >= trial;

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? cur - trial : cur;
			root_s[i+1] <= {root_s[i][ROOT_BITS-2:0], ge};
			rad_s[i+1] <= rad_s[i] << 2;
		end
	end

	assign root = root_s[ROOT_BITS];

endmodule

[sv/dpec_div.sv]
module dpec_div #(
	parameter int MAG_W = 28,
	parameter int Q_W = 17
) (
	input  logic             clk,
	input  logic [MAG_W-1:0] den,
	input  logic [MAG_W-1:0] num_a,
	input  logic [MAG_W-1:0] num_b,
	output logic [MAG_W-1:0] den_out,
	output logic [Q_W-1:0]   quo_a,
	output logic [Q_W-1:0]   quo_b
);

	logic [MAG_W-1:0] den_s [Q_W+1];
	logic [MAG_W-1:0] rem_s [2][Q_W+1];
	logic [Q_W-1:0]   low_s [2][Q_W+1];
	logic [Q_W-1:0]   quo_s [2][Q_W+1];
	logic [MAG_W-1:0] num [2];

	assign num[0] = num_a;
	assign num[1] = num_b;
	assign den_s[0] = den;

	for (genvar i = 0; i < Q_W; i++) begin : g_den
		always_ff @(posedge clk) begin
			den_s[i+1] <= den_s[i];
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		assign rem_s[l][0] = num[l] >> 1;
		assign low_s[l][0] = {num[l][0], {(Q_W-1){1'b0}}};
		assign quo_s[l][0] = '0;

		for (genvar i = 0; i < Q_W; i++) begin : g_step
			logic [MAG_W:0] cur;
			logic           ge;

			assign cur = {rem_s[l][i], low_s[l][i][Q_W-1]};
			assign ge = cur >= {1'b0, den_s[i]};

			always_ff @(posedge clk) begin
				rem_s[l][i+1] <= ge ? MAG_W'(cur - {1'b0, den_s[i]}) : MAG_W'(cur);
				low_s[l][i+1] <= low_s[l][i] << 1;
				quo_s[l][i+1] <= {quo_s[l][i][Q_W-2:0], ge};
			end
		end
	end

	assign den_out = den_s[Q_W];
	assign quo_a = quo_s[0][Q_W];
	assign quo_b = quo_s[1][Q_W];

endmodule

[sv/disk_pair_elastic_collision_top.sv]
// Elastic collision of two equal disks, one candidate pair per transaction.
// Input: drive start high with the eight position and velocity words of a
// pair; the transaction is taken at a rising edge with start high and busy
// low. busy stays low, so a new pair may enter on every cycle.
// Output: done is high for one cycle with the updated pair and
// contact_status (none, resolved, coincident centres). Results leave in
// the order the pairs entered.
// Stages: capture, offset and magnitude, squares, contact test, the square
// root (one result bit per stage), the two-lane normal divider (one
// quotient bit per stage), then normal, products, exchange and apply.
// Throughput is one pair per cycle.
// Configuration: APB register 0 holds the shared radius (unsigned Q format);
// write it only while no transaction is in flight.
// Reset clears the radius to 5.0 and drops every transaction in flight.
// The receiver cannot stall; results are presented once and not held.
module disk_pair_elastic_collision_top
	import dpec_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [WORD_BITS-1:0] first_pos_x,
	input  logic signed [WORD_BITS-1:0] first_pos_y,
	input  logic signed [WORD_BITS-1:0] first_vel_x,
	input  logic signed [WORD_BITS-1:0] first_vel_y,
	input  logic signed [WORD_BITS-1:0] second_pos_x,
	input  logic signed [WORD_BITS-1:0] second_pos_y,
	input  logic signed [WORD_BITS-1:0] second_vel_x,
	input  logic signed [WORD_BITS-1:0] second_vel_y,
	output logic                        done,
	output logic signed [WORD_BITS-1:0] new_first_pos_x,
	output logic signed [WORD_BITS-1:0] new_first_pos_y,
	output logic signed [WORD_BITS-1:0] new_first_vel_x,
	output logic signed [WORD_BITS-1:0] new_first_vel_y,
	output logic signed [WORD_BITS-1:0] new_second_pos_x,
	output logic signed [WORD_BITS-1:0] new_second_pos_y,
	output logic signed [WORD_BITS-1:0] new_second_vel_x,
	output logic signed [WORD_BITS-1:0] new_second_vel_y,
	output logic [1:0]                  contact_status
);

	localparam int WB = WORD_BITS;
	localparam int F = FRAC_BITS;
	localparam int MB = MAG_BITS;
	localparam int RB = RADIUS_BITS;
	localparam int QB = F + 1;
	localparam int FW = 8 * WB;
	localparam int CTX_W = FW + 5;
	localparam int CW = (WB + 1 > MB) ? WB + 1 : MB;
	localparam int SW = ((WB + 6 > RB + 3) ? WB + 6 : RB + 3) + 1;

	function automatic logic [WB-1:0] sat_w(input logic signed [SW-1:0] v);
		logic [SW-WB:0] top;
		top = v[SW-1:WB-1];
		if (top == '0 || top == '1) begin
			return v[WB-1:0];
		end else if (v[SW-1]) begin
			return {1'b1, {(WB-1){1'b0}}};
		end else begin
			return {1'b0, {(WB-1){1'b1}}};
		end
	endfunction

	// configuration
	logic [RB-1:0]   radius_q;
	logic [2*MB-1:0] lim_q;
	logic [MB-1:0]   two_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RB'(RADIUS_RESET_INT) << F;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS) begin
			radius_q <= pwdata[RB-1:0];
		end
	end

	assign two_r = {radius_q, 1'b0};

	always_ff @(posedge clk) begin
		lim_q <= two_r * two_r;
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_RADIUS) ? 32'(radius_q) : '0;
	assign busy = 1'b0;

	// s1: capture
	logic          vld_s1;
	logic [FW-1:0] ctx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= {second_vel_y, second_vel_x, second_pos_y, second_pos_x,
			first_vel_y, first_vel_x, first_pos_y, first_pos_x};
	end

	// s2: offset and magnitude
	logic signed [WB:0] dx, dy;
	logic [WB:0]        adx, ady;
	logic               box;

	assign dx = $signed({ctx_s1[5*WB-1], ctx_s1[4*WB +: WB]})
		- $signed({ctx_s1[WB-1], ctx_s1[0 +: WB]});
	assign dy = $signed({ctx_s1[6*WB-1], ctx_s1[5*WB +: WB]})
		- $signed({ctx_s1[2*WB-1], ctx_s1[WB +: WB]});
	assign adx = dx[WB] ? (WB+1)'(-dx) : (WB+1)'(dx);
	assign ady = dy[WB] ? (WB+1)'(-dy) : (WB+1)'(dy);
	assign box = (CW'(adx) < CW'(two_r)) && (CW'(ady) < CW'(two_r));

	logic          vld_s2, box_s2, sx_s2, sy_s2;
	logic [MB-1:0] adx_s2, ady_s2;
	logic [FW-1:0] ctx_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		box_s2 <= box;
		sx_s2 <= dx[WB];
		sy_s2 <= dy[WB];
		adx_s2 <= MB'(adx);
		ady_s2 <= MB'(ady);
		ctx_s2 <= ctx_s1;
	end

	// s3: squares
	logic            vld_s3, box_s3, sx_s3, sy_s3;
	logic [2*MB-1:0] sqx_s3, sqy_s3;
	logic [MB-1:0]   adx_s3, ady_s3;
	logic [FW-1:0]   ctx_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		box_s3 <= box_s2;
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
		sqx_s3 <= adx_s2 * adx_s2;
		sqy_s3 <= ady_s2 * ady_s2;
		adx_s3 <= adx_s2;
		ady_s3 <= ady_s2;
		ctx_s3 <= ctx_s2;
	end

	// s4: contact test
	logic [2*MB:0] ssum;
	logic          contact;
	status_t       status_c;

	assign ssum = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign contact = box_s3 && (ssum < {1'b0, lim_q});

	always_comb begin
		if (!contact) begin
			status_c = ST_NONE;
		end else if (ssum == '0) begin
			status_c = ST_COIN;
		end else begin
			status_c = ST_HIT;
		end
	end

	logic            vld_s4, sx_s4, sy_s4;
	logic [2*MB-1:0] rad_s4;
	logic [MB-1:0]   adx_s4, ady_s4;
	status_t         status_s4;
	logic [FW-1:0]   ctx_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sx_s4 <= sx_s3;
		sy_s4 <= sy_s3;
		rad_s4 <= contact ? (2*MB)'(ssum) : '0;
		adx_s4 <= adx_s3;
		ady_s4 <= ady_s3;
		status_s4 <= status_c;
		ctx_s4 <= ctx_s3;
	end

	// length and normal
	logic [MB-1:0]    root_len, adx_d, ady_d, den_d;
	logic [QB-1:0]    qx, qy;
	logic [CTX_W-1:0] ctx_d;

	dpec_sqrt #(.ROOT_BITS(MB)) u_sqrt (
		.clk  (clk),
		.rad  (rad_s4),
		.root (root_len)
	);

	dpec_dly #(.DATA_BITS(2*MB), .DEPTH(MB)) u_mag_dly (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_in  ({ady_s4, adx_s4}),
		.data_out ({ady_d, adx_d})
	);

	dpec_div #(.MAG_W(MB), .Q_W(QB)) u_div (
		.clk     (clk),
		.den     (root_len),
		.num_a   (adx_d),
		.num_b   (ady_d),
		.den_out (den_d),
		.quo_a   (qx),
		.quo_b   (qy)
	);

	dpec_dly #(.DATA_BITS(CTX_W), .DEPTH(MB + QB)) u_ctx_dly (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_in  ({vld_s4, sy_s4, sx_s4, status_s4, ctx_s4}),
		.data_out (ctx_d)
	);

	// s5: signed normal, differences, overlap
	logic signed [WB-1:0] f5 [8];
	logic signed [F+1:0]  nx_c, ny_c;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			f5[k] = $signed(ctx_d[k*WB +: WB]);
		end
	end

	assign nx_c = ctx_d[FW+2] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign ny_c = ctx_d[FW+3] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});

	logic                vld_s5;
	logic signed [F+1:0] nx_s5, ny_s5;
	logic signed [WB:0]  dvx_s5, dvy_s5;
	logic [RB-1:0]       ov_s5;
	logic [FW+1:0]       ctx_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= ctx_d[FW+4];
		end
	end

	always_ff @(posedge clk) begin
		nx_s5 <= nx_c;
		ny_s5 <= ny_c;
		dvx_s5 <= $signed({f5[2][WB-1], f5[2]}) - $signed({f5[6][WB-1], f5[6]});
		dvy_s5 <= $signed({f5[3][WB-1], f5[3]}) - $signed({f5[7][WB-1], f5[7]});
		ov_s5 <= RB'((two_r - den_d) >> 1);
		ctx_s5 <= ctx_d[FW+1:0];
	end

	// s6: products along the normal
	logic                   vld_s6;
	logic signed [WB+F+2:0] mx_s6, my_s6;
	logic signed [RB+F+2:0] oxf_s6, oyf_s6;
	logic signed [F+1:0]    nx_s6, ny_s6;
	logic [FW+1:0]          ctx_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		mx_s6 <= dvx_s5 * nx_s5;
		my_s6 <= dvy_s5 * ny_s5;
		oxf_s6 <= $signed({1'b0, ov_s5}) * nx_s5;
		oyf_s6 <= $signed({1'b0, ov_s5}) * ny_s5;
		nx_s6 <= nx_s5;
		ny_s6 <= ny_s5;
		ctx_s6 <= ctx_s5;
	end

	// s7: normal speed, push-apart offsets
	logic signed [WB+F+3:0] psum, psh;
	logic signed [RB+F+2:0] oxsh, oysh;

	assign psum = (WB+F+4)'(mx_s6) + (WB+F+4)'(my_s6);
	assign psh = psum >>> F;
	assign oxsh = oxf_s6 >>> F;
	assign oysh = oyf_s6 >>> F;

	logic                vld_s7;
	logic signed [WB+3:0] p_s7;
	logic signed [RB+2:0] ox_s7, oy_s7;
	logic signed [F+1:0]  nx_s7, ny_s7;
	logic [FW+1:0]        ctx_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		p_s7 <= $signed(psh[WB+3:0]);
		ox_s7 <= $signed(oxsh[RB+2:0]);
		oy_s7 <= $signed(oysh[RB+2:0]);
		nx_s7 <= nx_s6;
		ny_s7 <= ny_s6;
		ctx_s7 <= ctx_s6;
	end

	// s8: velocity exchange products
	logic                   vld_s8;
	logic signed [WB+F+5:0] kxf_s8, kyf_s8;
	logic signed [RB+2:0]   ox_s8, oy_s8;
	logic [FW+1:0]          ctx_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else begin
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		kxf_s8 <= p_s7 * nx_s7;
		kyf_s8 <= p_s7 * ny_s7;
		ox_s8 <= ox_s7;
		oy_s8 <= oy_s7;
		ctx_s8 <= ctx_s7;
	end

	// s9: apply, saturate, present
	logic signed [WB+F+5:0] kxsh, kysh;
	logic signed [WB+5:0]   kx, ky;
	logic signed [WB-1:0]   f8 [8];
	logic [WB-1:0]          res_c [8];
	logic                   hit;

	assign kxsh = kxf_s8 >>> F;
	assign kysh = kyf_s8 >>> F;
	assign kx = $signed(kxsh[WB+5:0]);
	assign ky = $signed(kysh[WB+5:0]);
	assign hit = ctx_s8[FW +: 2] == ST_HIT;

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			f8[k] = $signed(ctx_s8[k*WB +: WB]);
		end
		if (hit) begin
			res_c[0] = sat_w(SW'(f8[0]) - SW'(ox_s8));
			res_c[1] = sat_w(SW'(f8[1]) - SW'(oy_s8));
			res_c[2] = sat_w(SW'(f8[2]) - SW'(kx));
			res_c[3] = sat_w(SW'(f8[3]) - SW'(ky));
			res_c[4] = sat_w(SW'(f8[4]) + SW'(ox_s8));
			res_c[5] = sat_w(SW'(f8[5]) + SW'(oy_s8));
			res_c[6] = sat_w(SW'(f8[6]) + SW'(kx));
			res_c[7] = sat_w(SW'(f8[7]) + SW'(ky));
		end else begin
			for (int k = 0; k < 8; k++) begin
				res_c[k] = f8[k];
			end
		end
	end

	logic          done_s9;
	logic [WB-1:0] res_s9 [8];
	logic [1:0]    status_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s9 <= 1'b0;
		end else begin
			done_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) begin
			res_s9[k] <= res_c[k];
		end
		status_s9 <= ctx_s8[FW +: 2];
	end

	assign done = done_s9;
	assign new_first_pos_x = $signed(res_s9[0]);
	assign new_first_pos_y = $signed(res_s9[1]);
	assign new_first_vel_x = $signed(res_s9[2]);
	assign new_first_vel_y = $signed(res_s9[3]);
	assign new_second_pos_x = $signed(res_s9[4]);
	assign new_second_pos_y = $signed(res_s9[5]);
	assign new_second_vel_x = $signed(res_s9[6]);
	assign new_second_vel_y = $signed(res_s9[7]);
	assign contact_status = status_s9;

endmodule

[sv/dpec_chk.sv]
module dpec_chk
	import dpec_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [1:0]                  contact_status,
	input logic signed [WORD_BITS-1:0] first_pos_x,
	input logic signed [WORD_BITS-1:0] second_vel_y,
	input logic signed [WORD_BITS-1:0] new_first_pos_x,
	input logic signed [WORD_BITS-1:0] new_second_vel_y
);

	localparam int LAT = MAG_BITS + FRAC_BITS + 10;
	localparam int CB = $clog2(LAT + 1);

	logic [CB-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cnt_q != CB'(LAT)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (contact_status == ST_NONE || contact_status == ST_HIT
			|| contact_status == ST_COIN))
		else $error("undefined contact status");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == CB'(LAT) |-> done == $past(start && !busy, LAT))
		else $error("result strobe does not match accepted transaction");

	a_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == CB'(LAT) && done && contact_status != ST_HIT) |->
			(new_first_pos_x == $past(first_pos_x, LAT)
			&& new_second_vel_y == $past(second_vel_y, LAT)))
		else $error("pair modified without a resolved collision");

endmodule

bind disk_pair_elastic_collision_top dpec_chk #(
	.FRAC_BITS (FRAC_BITS),
	.WORD_BITS (WORD_BITS)
) u_dpec_chk (.*);

[test/dpec_checker.sv]
`timescale 1ns / 1ps

module dpec_checker
	import dpec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] first_pos_x,
	input  logic [31:0] first_pos_y,
	input  logic [31:0] first_vel_x,
	input  logic [31:0] first_vel_y,
	input  logic [31:0] second_pos_x,
	input  logic [31:0] second_pos_y,
	input  logic [31:0] second_vel_x,
	input  logic [31:0] second_vel_y,
	input  logic        done,
	input  logic [31:0] new_first_pos_x,
	input  logic [31:0] new_first_pos_y,
	input  logic [31:0] new_first_vel_x,
	input  logic [31:0] new_first_vel_y,
	input  logic [31:0] new_second_pos_x,
	input  logic [31:0] new_second_pos_y,
	input  logic [31:0] new_second_vel_x,
	input  logic [31:0] new_second_vel_y,
	input  logic [1:0]  contact_status,
	output int          errors,
	output int          pending,
	output int          hits,
	output int          coincident
);

	typedef logic [31:0] pair_words_t [8];
	typedef struct {
		pair_words_t w;
		status_t     st;
	} collision_t;

	localparam string FIELD_NAME [8] = '{"new_first_pos_x", "new_first_pos_y",
		"new_first_vel_x", "new_first_vel_y", "new_second_pos_x", "new_second_pos_y",
		"new_second_vel_x", "new_second_vel_y"};

	logic [RADIUS_BITS-1:0] radius;
	collision_t expected_q [$];

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] clamp_word(longint v);
		if (v > 64'sd2147483647) return 32'h7fff_ffff;
		if (v < -64'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic collision_t resolve_pair(pair_words_t a, logic [RADIUS_BITS-1:0] rad);
		collision_t r;
		longint x1, y1, v1x, v1y, x2, y2, v2x, v2y;
		longint dx, dy, adx, ady, tr, s, lim, dlen, nx, ny, p, kx, ky, ov, ox, oy;
		x1 = longint'(signed'(a[0]));
		y1 = longint'(signed'(a[1]));
		v1x = longint'(signed'(a[2]));
		v1y = longint'(signed'(a[3]));
		x2 = longint'(signed'(a[4]));
		y2 = longint'(signed'(a[5]));
		v2x = longint'(signed'(a[6]));
		v2y = longint'(signed'(a[7]));
		r.w = a;
		r.st = ST_NONE;
		dx = x2 - x1;
		dy = y2 - y1;
		tr = longint'(rad) * 2;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		if (adx < tr && ady < tr) begin
			s = adx * adx + ady * ady;
			lim = tr * tr;
			if (s < lim) begin
				if (s == 0) begin
					r.st = ST_COIN;
				end else begin
					dlen = longint'(int_sqrt(s));
					nx = (dx * 65536) / dlen;
					ny = (dy * 65536) / dlen;
					p = ((v1x - v2x) * nx + (v1y - v2y) * ny) >>> 16;
					kx = (p * nx) >>> 16;
					ky = (p * ny) >>> 16;
					ov = (tr - dlen) / 2;
					ox = (ov * nx) >>> 16;
					oy = (ov * ny) >>> 16;
					r.w[0] = clamp_word(x1 - ox);
					r.w[1] = clamp_word(y1 - oy);
					r.w[2] = clamp_word(v1x - kx);
					r.w[3] = clamp_word(v1y - ky);
					r.w[4] = clamp_word(x2 + ox);
					r.w[5] = clamp_word(y2 + oy);
					r.w[6] = clamp_word(v2x + kx);
					r.w[7] = clamp_word(v2y + ky);
					r.st = ST_HIT;
				end
			end
		end
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		pair_words_t in_w, out_w;
		collision_t exp_r;
		bit bad;
		if (!arst_n) begin
			radius <= RADIUS_BITS'(RADIUS_RESET_INT << 16);
			expected_q.delete();
			errors <= 0;
			hits <= 0;
			coincident <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS)
				radius <= pwdata[RADIUS_BITS-1:0];
			if (start && !busy) begin
				in_w = '{first_pos_x, first_pos_y, first_vel_x, first_vel_y,
					second_pos_x, second_pos_y, second_vel_x, second_vel_y};
				expected_q.push_back(resolve_pair(in_w, radius));
			end
			if (done) begin
				out_w = '{new_first_pos_x, new_first_pos_y, new_first_vel_x, new_first_vel_y,
					new_second_pos_x, new_second_pos_y, new_second_vel_x, new_second_vel_y};
				if (expected_q.size() == 0) begin
					if (errors < 10)
						$display("%0t: result with no transaction outstanding", $realtime);
					errors <= errors + 1;
				end else begin
					exp_r = expected_q.pop_front();
					bad = 0;
					for (int i = 0; i < 8; i++)
						if (out_w[i] !== exp_r.w[i]) begin
							bad = 1;
							if (errors < 10)
								$display("%0t: %s expected %h got %h", $realtime,
									FIELD_NAME[i], exp_r.w[i], out_w[i]);
						end
					if (contact_status !== exp_r.st) begin
						bad = 1;
						if (errors < 10)
							$display("%0t: contact_status expected %0d got %0d", $realtime,
								exp_r.st, contact_status);
					end
					if (bad) errors <= errors + 1;
					if (exp_r.st == ST_HIT) hits <= hits + 1;
					if (exp_r.st == ST_COIN) coincident <= coincident + 1;
				end
			end
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
	import dpec_pkg::*;

	localparam int LATENCY = MAG_BITS + 16 + 9;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASES = 5;

	typedef logic [31:0] pair_words_t [8];

	logic clk, arst_n;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic start, busy, done;
	logic [31:0] in_w [8];
	logic signed [31:0] out_w [8];
	logic [1:0] contact_status;
	int errors, pending, hits, coincident;
	int idle_cycles, items_sent;
	int idle_pct [PHASES] = '{0, 69, 0, 21, 69};
	logic [RADIUS_BITS-1:0] radius_set [PHASES];
	logic [RADIUS_BITS-1:0] cur_radius;

	disk_pair_elastic_collision_top dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy),
		.first_pos_x(in_w[0]), .first_pos_y(in_w[1]),
		.first_vel_x(in_w[2]), .first_vel_y(in_w[3]),
		.second_pos_x(in_w[4]), .second_pos_y(in_w[5]),
		.second_vel_x(in_w[6]), .second_vel_y(in_w[7]),
		.done(done),
		.new_first_pos_x(out_w[0]), .new_first_pos_y(out_w[1]),
		.new_first_vel_x(out_w[2]), .new_first_vel_y(out_w[3]),
		.new_second_pos_x(out_w[4]), .new_second_pos_y(out_w[5]),
		.new_second_vel_x(out_w[6]), .new_second_vel_y(out_w[7]),
		.contact_status(contact_status)
	);

	dpec_checker chk (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.pready(pready), .paddr(paddr), .pwdata(pwdata), .start(start), .busy(busy),
		.first_pos_x(in_w[0]), .first_pos_y(in_w[1]),
		.first_vel_x(in_w[2]), .first_vel_y(in_w[3]),
		.second_pos_x(in_w[4]), .second_pos_y(in_w[5]),
		.second_vel_x(in_w[6]), .second_vel_y(in_w[7]),
		.done(done),
		.new_first_pos_x(out_w[0]), .new_first_pos_y(out_w[1]),
		.new_first_vel_x(out_w[2]), .new_first_vel_y(out_w[3]),
		.new_second_pos_x(out_w[4]), .new_second_pos_y(out_w[5]),
		.new_second_vel_x(out_w[6]), .new_second_vel_y(out_w[7]),
		.contact_status(contact_status),
		.errors(errors), .pending(pending), .hits(hits), .coincident(coincident)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_radius(logic [RADIUS_BITS-1:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= 3'({REG_RADIUS, 2'b00});
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		cur_radius = value;
	endtask

	task automatic send_pair(pair_words_t w, int idle);
		while ($urandom_range(99) < idle) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		for (int i = 0; i < 8; i++) in_w[i] <= w[i];
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	function automatic logic [31:0] rand_vel();
		case ($urandom_range(3))
			0: return $urandom_range(32'h0004_0000);
			1: return -$urandom_range(32'h0004_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] near_offset(logic [RADIUS_BITS-1:0] rad);
		longint tr;
		tr = longint'(rad) * 2;
		if (tr == 0) return 0;
		case ($urandom_range(9))
			0: return 32'(tr);
			1: return 32'(-tr);
			2: return 32'(tr - 1);
			3: return 0;
			default: return 32'(longint'($urandom_range(32'(2 * tr))) - tr);
		endcase
	endfunction

	function automatic pair_words_t make_pair(logic [RADIUS_BITS-1:0] rad);
		pair_words_t w;
		for (int i = 0; i < 8; i++) w[i] = $urandom;
		if ($urandom_range(9) < 8) begin
			if ($urandom_range(9) == 0) begin
				w[0] = 32'h7fff_ffff - $urandom_range(32'(rad));
				w[1] = 32'h8000_0000 + $urandom_range(32'(rad));
			end
			w[4] = w[0] + near_offset(rad);
			w[5] = w[1] + near_offset(rad);
			w[2] = rand_vel();
			w[3] = rand_vel();
			w[6] = rand_vel();
			w[7] = rand_vel();
			if ($urandom_range(19) == 0) begin
				w[4] = w[0];
				w[5] = w[1];
			end
		end
		return w;
	endfunction

	task automatic send_offset(logic [31:0] x, logic [31:0] y, logic [31:0] ox,
			logic [31:0] oy, logic [31:0] va, logic [31:0] vb);
		send_pair('{x, y, va, vb, x + ox, y + oy, -va, vb ^ 32'h0001_0000}, 0);
	endtask

	task automatic directed_pairs(int phase);
		logic [31:0] tr;
		tr = 32'(longint'(cur_radius) * 2);
		send_pair('{default: 32'h0}, 0);
		send_pair('{default: 32'h7fff_ffff}, 0);
		send_pair('{default: 32'h8000_0000}, 0);
		if (phase == 0) begin
			send_pair('{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
				32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 0);
			send_offset(0, 0, 32'h0001_0000, 0, 32'h7fff_ffff, 32'h8000_0000);
			send_offset(32'h0010_0000, 32'hfff0_0000, 0, 32'h0003_0000, 32'h0002_0000, 32'hfffe_0000);
			send_offset(0, 0, 32'h0003_0000, 32'h0004_0000, 32'h0001_8000, 32'h0000_4000);
			send_offset(0, 0, tr, 0, 32'h0001_0000, 0);
			send_offset(0, 0, tr - 1, 0, 32'h0001_0000, 0);
			send_offset(0, 0, 0, -tr + 1, 0, 32'h0005_0000);
			send_offset(0, 0, tr * 4 / 5, tr * 4 / 5, 32'h0001_0000, 0);
			send_offset(32'h1234_5678, 32'h8765_4321, 32'hfffd_8000, 32'hffff_0000,
				32'h8000_0000, 32'h7fff_ffff);
			send_offset(0, 0, 1, 0, 32'h0001_0000, 32'hffff_0000);
			send_offset(0, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		end else if (phase == 2) begin
			send_offset(32'h7fff_ffff, 32'h7fff_ffff, 32'hfff0_0000, 32'hfff8_0000,
				32'h7fff_ffff, 32'h8000_0000);
			send_offset(32'h8000_0000, 32'h8000_0000, 32'h0000_0100, 32'h0010_0000,
				32'h8000_0000, 32'h7fff_ffff);
			send_offset(0, 0, tr - 1, 0, 32'h7fff_ffff, 32'h7fff_ffff);
		end
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = 0;
		pwdata = 0;
		start = 0;
		for (int i = 0; i < 8; i++) in_w[i] = 0;
		items_sent = 0;
		cur_radius = RADIUS_BITS'(RADIUS_RESET_INT << 16);
		radius_set = '{RADIUS_BITS'(RADIUS_RESET_INT << 16), 0, RADIUS_BITS'(1 << 26),
			RADIUS_BITS'($urandom_range(1, 1 << 22)), 1};
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				start <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
				repeat (LATENCY + 4) @(posedge clk);
				write_radius(radius_set[ph]);
			end
			directed_pairs(ph);
			for (int n = 0; n < 200; n++) send_pair(make_pair(cur_radius), idle_pct[ph]);
		end
		start <= 0;
		@(posedge clk);
		for (int t = 0; pending != 0 && t < 20 * LATENCY; t++) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		$display("%0d pairs over %0d radius settings: %0d collisions resolved, %0d coincident",
			items_sent, PHASES, hits, coincident);
		if (errors == 0 && pending == 0) begin
			$display("tb passed");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending);
			$display("tb failed");
		end
		$finish;
	end

endmodule
